>>> rtl/hsn_pkg.sv
// hsn_pkg: shared constants, register indexes, state and job types
// for the heightmap surface normal stream; no dependencies
package hsn_pkg;

    localparam int MAX_ROW_CELLS = 1024;
    localparam int SAMPLE_W      = 16;
    localparam int DIFF_W        = 18;
    localparam int COL_W         = 10;
    localparam int ROW_W         = 16;
    localparam int WIDTH_W       = 11;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int TDATA_W       = 80;
    localparam int PAD_W         = 7;

    localparam logic [WIDTH_W-1:0] RESET_WIDTH   = 11'd1024;
    localparam logic [ROW_W-1:0]   RESET_HEIGHT  = 16'd1024;
    localparam logic [15:0]        RESET_SPACING = 16'd1;

    localparam logic [CFG_IDX_W-1:0] REG_RASTER_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RASTER_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SPACING  = 8'd2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_JOBS,
        F_WRITE
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ,
        B_SUM,
        B_ROOT,
        B_DIVP,
        B_DIV,
        B_DONE
    } t_bstate;

    typedef struct packed {
        logic signed [DIFF_W-1:0] sx;
        logic signed [DIFF_W-1:0] sy;
        logic [COL_W-1:0]         col;
        logic [ROW_W-1:0]         row;
        logic                     last;
    } t_job;

endpackage

>>> rtl/heightmap_surface_normal_stream.sv
// heightmap_surface_normal_stream: top level joining front, job queue and back
// depends on hsn_pkg, hsn_front, hsn_fifo, hsn_back (and hsn_ram below front)
//
// Elevation samples enter in raster order, one per item. Each cell's unit normal
// (Q1.15) leaves with its column and row one row late; cells of the last row
// leave as their right neighbor arrives. The front takes a new sample only when
// it is done with the last one (accept, line-buffer reads, one job slot at a time
// for three slots, write), and waits longer while the job queue is full; the back
// works on one job at a time through the bit-serial square root (32 steps) and
// the divider (15 steps), so a stream of one result per sample is paced by the back.
// Any configuration write restarts the frame.
module heightmap_surface_normal_stream #(
    parameter int MAX_ROW_CELLS = hsn_pkg::MAX_ROW_CELLS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [hsn_pkg::SAMPLE_W-1:0]       s_axis_tdata,   // elevation_sample
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // normal_x, normal_y, normal_z, cell_column, cell_row, zero fill
    output logic [hsn_pkg::TDATA_W-1:0]        m_axis_tdata,
    output logic                               m_axis_tlast,   // run_last
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hsn_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hsn_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    hsn_pkg::t_job              push_job, pop_job;
    logic                       q_push, q_pop, q_full, q_empty;
    logic [15:0]                spacing;
    logic signed [15:0]         nx, ny;
    logic [14:0]                nz;
    logic [hsn_pkg::COL_W-1:0]  col;
    logic [hsn_pkg::ROW_W-1:0]  row;

    hsn_front #(
        .MAX_ROW_CELLS (MAX_ROW_CELLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_sample    (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_spacing   (spacing),
        .o_push      (q_push),
        .o_job       (push_job),
        .i_full      (q_full)
    );

    hsn_fifo #(
        .WIDTH ($bits(hsn_pkg::t_job)),
        .DEPTH (hsn_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (pop_job),
        .o_empty (q_empty)
    );

    hsn_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_spacing (spacing),
        .i_empty   (q_empty),
        .i_job     (pop_job),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_nx      (nx),
        .o_ny      (ny),
        .o_nz      (nz),
        .o_col     (col),
        .o_row     (row),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {{hsn_pkg::PAD_W{1'b0}}, row, col, nz, ny, nx};
    assign o_cfg_ready  = 1'b1;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full) else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("job queue underflow");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("front took a second item while busy");
`endif

endmodule

>>> rtl/hsn_ram.sv
// hsn_ram: generic single-write, single-read memory with registered read
// no dependencies
module hsn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/hsn_fifo.sv
// hsn_fifo: small register queue of cell jobs between front and back
// depends on nothing but its parameters
module hsn_fifo #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [PW:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (32'(r_wptr) == DEPTH - 1) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (32'(r_rptr) == DEPTH - 1) ? '0 : r_rptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_full  = (32'(r_count) == DEPTH);
    assign o_empty = (r_count == '0);

endmodule

>>> rtl/hsn_front.sv
// hsn_front: configuration registers, raster position, line buffer access
// and forming of cell jobs (differences); uses hsn_pkg and hsn_ram
module hsn_front #(
    parameter int MAX_ROW_CELLS = hsn_pkg::MAX_ROW_CELLS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [hsn_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                             i_cfg_valid,
    input  logic [hsn_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hsn_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic [15:0]                      o_spacing,
    output logic                             o_push,
    output hsn_pkg::t_job                    o_job,
    input  logic                             i_full
);

    localparam int CW = $clog2(MAX_ROW_CELLS);
    localparam int SW = hsn_pkg::SAMPLE_W;

    hsn_pkg::t_fstate r_state, n_state;

    logic [hsn_pkg::WIDTH_W-1:0] r_width;
    logic [hsn_pkg::ROW_W-1:0]   r_height;
    logic [15:0]                 r_spacing;
    logic [CW-1:0]               r_col;
    logic [hsn_pkg::ROW_W-1:0]   r_row;
    logic signed [SW-1:0]        r_prev;
    logic signed [SW-1:0]        r_s;
    logic [2:0]                  r_ph;
    logic [1:0]                  r_jp;
    logic signed [SW-1:0]        r_np1, r_n0, r_o0, r_om1, r_nm2;

    logic [CW-1:0]               lastc;
    logic [CW-1:0]               c;
    logic [hsn_pkg::ROW_W-1:0]   lastr;
    logic                        last_row, has_a, has_b, has_c;

    logic                        ram_we;
    logic [CW-1:0]               raddr;
    logic [2*SW-1:0]             rdata;

    logic                        job_on, advance;
    logic signed [SW-1:0]        j_left, j_right, j_up, j_down;
    logic                        xedge, yedge;
    logic [CW-1:0]               jcol;
    logic [hsn_pkg::ROW_W-1:0]   jrow;
    logic                        jlast;
    logic signed [hsn_pkg::DIFF_W-1:0] dx, dy;

    always_comb begin
        if (r_width == '0) begin
            lastc = '0;
        end else if (32'(r_width) > MAX_ROW_CELLS) begin
            lastc = CW'(MAX_ROW_CELLS - 1);
        end else begin
            lastc = CW'(r_width - 11'd1);
        end
        lastr    = (r_height == '0) ? '0 : r_height - 16'd1;
        c        = (r_col > lastc) ? lastc : r_col;
        last_row = (r_row == lastr);
        has_a    = (r_row != '0);
        has_b    = last_row && (c != '0);
        has_c    = last_row && (c == lastc);
    end

    // line buffer entry: older row in the upper half, newer row in the lower
    hsn_ram #(
        .WIDTH (2*SW),
        .DEPTH (MAX_ROW_CELLS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (c),
        .i_wdata ({r_n0, r_s}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        j_left  = r_n0;
        j_right = r_n0;
        j_up    = r_n0;
        j_down  = r_s;
        xedge   = 1'b1;
        yedge   = 1'b1;
        jcol    = c;
        jrow    = r_row;
        jlast   = 1'b1;
        job_on  = 1'b0;
        unique case (r_jp)
            2'd0: begin
                job_on  = has_a;
                j_left  = (c != '0) ? r_om1 : r_n0;
                j_right = (c != lastc) ? r_np1 : r_n0;
                j_up    = (r_row != 16'd1) ? r_o0 : r_n0;
                j_down  = r_s;
                xedge   = (c == '0) || (c == lastc);
                yedge   = (r_row == 16'd1);
                jcol    = c;
                jrow    = r_row - 16'd1;
                jlast   = !has_b && !has_c;
            end
            2'd1: begin
                job_on  = has_b;
                j_left  = (32'(c) >= 2) ? r_nm2 : r_prev;
                j_right = r_s;
                j_up    = (r_row != '0) ? r_om1 : r_prev;
                j_down  = r_prev;
                xedge   = (32'(c) == 1);
                yedge   = 1'b1;
                jcol    = c - CW'(1);
                jrow    = r_row;
                jlast   = !has_c;
            end
            default: begin
                job_on  = has_c;
                j_left  = (lastc != '0) ? r_prev : r_s;
                j_right = r_s;
                j_up    = (r_row != '0) ? r_n0 : r_s;
                j_down  = r_s;
                xedge   = 1'b1;
                yedge   = 1'b1;
                jcol    = c;
                jrow    = r_row;
                jlast   = 1'b1;
            end
        endcase
        dx = hsn_pkg::DIFF_W'(j_right) - hsn_pkg::DIFF_W'(j_left);
        dy = hsn_pkg::DIFF_W'(j_down) - hsn_pkg::DIFF_W'(j_up);
        if (xedge) begin
            dx = dx <<< 1;
        end
        if (yedge) begin
            dy = dy <<< 1;
        end
    end

    assign o_job.sx   = dx;
    assign o_job.sy   = dy;
    assign o_job.col  = hsn_pkg::COL_W'(jcol);
    assign o_job.row  = jrow;
    assign o_job.last = jlast;

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        ram_we  = 1'b0;
        advance = 1'b0;
        unique case (r_ph)
            3'd0:    raddr = (c != lastc) ? c + CW'(1) : c;
            3'd1:    raddr = c;
            3'd2:    raddr = (c != '0) ? c - CW'(1) : c;
            default: raddr = (32'(c) >= 2) ? c - CW'(2) : c;
        endcase
        unique case (r_state)
            hsn_pkg::F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = hsn_pkg::F_READ;
                end
            end
            hsn_pkg::F_READ: begin
                if (r_ph == 3'd4) begin
                    n_state = hsn_pkg::F_JOBS;
                end
            end
            hsn_pkg::F_JOBS: begin
                if (!job_on) begin
                    advance = 1'b1;
                end else if (!i_full) begin
                    o_push  = 1'b1;
                    advance = 1'b1;
                end
                if (advance && r_jp == 2'd2) begin
                    n_state = hsn_pkg::F_WRITE;
                end
            end
            hsn_pkg::F_WRITE: begin
                ram_we  = 1'b1;
                n_state = hsn_pkg::F_IDLE;
            end
            default: n_state = hsn_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hsn_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= hsn_pkg::RESET_WIDTH;
            r_height  <= hsn_pkg::RESET_HEIGHT;
            r_spacing <= hsn_pkg::RESET_SPACING;
            r_col     <= '0;
            r_row     <= '0;
            r_prev    <= '0;
            r_ph      <= '0;
            r_jp      <= '0;
        end else begin
            unique case (r_state)
                hsn_pkg::F_IDLE: begin
                    r_ph <= '0;
                    r_jp <= '0;
                end
                hsn_pkg::F_READ: begin
                    r_ph <= r_ph + 3'd1;
                end
                hsn_pkg::F_JOBS: begin
                    if (advance) begin
                        r_jp <= r_jp + 2'd1;
                    end
                end
                hsn_pkg::F_WRITE: begin
                    r_prev <= r_s;
                    if (c == lastc) begin
                        r_col <= '0;
                        r_row <= last_row ? '0 : r_row + 16'd1;
                    end else begin
                        r_col <= c + CW'(1);
                    end
                end
                default: ;
            endcase
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    hsn_pkg::REG_RASTER_WIDTH:  r_width   <= i_cfg_data[hsn_pkg::WIDTH_W-1:0];
                    hsn_pkg::REG_RASTER_HEIGHT: r_height  <= i_cfg_data;
                    hsn_pkg::REG_CELL_SPACING:  r_spacing <= i_cfg_data;
                    default: ;
                endcase
                r_col <= '0;
                r_row <= '0;
            end
        end
    end

    // sample and line buffer reads
    always_ff @(posedge i_clk) begin
        if (r_state == hsn_pkg::F_IDLE && i_valid) begin
            r_s <= i_sample;
        end
        if (r_state == hsn_pkg::F_READ) begin
            unique case (r_ph)
                3'd1: r_np1 <= rdata[SW-1:0];
                3'd2: begin
                    r_n0 <= rdata[SW-1:0];
                    r_o0 <= rdata[2*SW-1:SW];
                end
                3'd3: r_om1 <= rdata[2*SW-1:SW];
                3'd4: r_nm2 <= rdata[SW-1:0];
                default: ;
            endcase
        end
    end

    assign o_spacing = r_spacing;

endmodule

>>> rtl/hsn_back.sv
// hsn_back: turns one cell job into a unit normal by an iterative square
// root and three shared-step restoring dividers; uses hsn_pkg
module hsn_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [15:0]                    i_spacing,
    input  logic                           i_empty,
    input  hsn_pkg::t_job                  i_job,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [15:0]             o_nx,
    output logic signed [15:0]             o_ny,
    output logic [14:0]                    o_nz,
    output logic [hsn_pkg::COL_W-1:0]      o_col,
    output logic [hsn_pkg::ROW_W-1:0]      o_row,
    output logic                           o_last
);

    localparam int AW = 17;
    localparam int VW = 63;
    localparam int MW = 32;
    localparam int DW = 47;

    hsn_pkg::t_bstate r_state, n_state;

    logic [AW-1:0]              r_a   [3];
    logic [1:0]                 r_neg;
    logic [2*AW-1:0]            r_sq  [3];
    logic [DW-1:0]              r_rem [3];
    logic [14:0]                r_q   [3];
    logic [2:0]                 r_sat;
    logic [DW-1:0]              r_dm;
    logic [VW-1:0]              r_v, r_res, r_bit;
    logic [4:0]                 r_k;
    logic [hsn_pkg::COL_W-1:0]  r_col;
    logic [hsn_pkg::ROW_W-1:0]  r_row;
    logic                       r_last;
    logic                       r_ovalid;
    logic signed [15:0]         r_nx, r_ny;
    logic [14:0]                r_nz;
    logic [hsn_pkg::COL_W-1:0]  r_ocol;
    logic [hsn_pkg::ROW_W-1:0]  r_orow;
    logic                       r_olast;

    logic [15:0]                sp;
    logic [VW-1:0]              trial;
    logic [MW-1:0]              m;
    logic                       load;
    logic [14:0]                qf [3];

    always_comb begin
        sp    = (i_spacing == '0) ? 16'd1 : i_spacing;
        trial = r_res + r_bit;
        m     = r_res[MW-1:0];
        for (int i = 0; i < 3; i++) begin
            qf[i] = r_sat[i] ? 15'h7fff : r_q[i];
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        load    = 1'b0;
        unique case (r_state)
            hsn_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = hsn_pkg::B_SQ;
                end
            end
            hsn_pkg::B_SQ:   n_state = hsn_pkg::B_SUM;
            hsn_pkg::B_SUM:  n_state = hsn_pkg::B_ROOT;
            hsn_pkg::B_ROOT: if (r_k == 5'd31) n_state = hsn_pkg::B_DIVP;
            hsn_pkg::B_DIVP: n_state = hsn_pkg::B_DIV;
            hsn_pkg::B_DIV:  if (r_k == 5'd14) n_state = hsn_pkg::B_DONE;
            hsn_pkg::B_DONE: begin
                if (!r_ovalid || i_ready) begin
                    load    = 1'b1;
                    n_state = hsn_pkg::B_IDLE;
                end
            end
            default: n_state = hsn_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hsn_pkg::B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            hsn_pkg::B_IDLE: begin
                r_a[0]   <= i_job.sx[hsn_pkg::DIFF_W-1] ? AW'(-i_job.sx) : AW'(i_job.sx);
                r_a[1]   <= i_job.sy[hsn_pkg::DIFF_W-1] ? AW'(-i_job.sy) : AW'(i_job.sy);
                r_a[2]   <= {sp, 1'b0};
                r_neg    <= {i_job.sy[hsn_pkg::DIFF_W-1], i_job.sx[hsn_pkg::DIFF_W-1]};
                r_col    <= i_job.col;
                r_row    <= i_job.row;
                r_last   <= i_job.last;
            end
            hsn_pkg::B_SQ: begin
                for (int i = 0; i < 3; i++) begin
                    r_sq[i] <= r_a[i] * r_a[i];
                end
            end
            hsn_pkg::B_SUM: begin
                r_v   <= {1'b0, (36'(r_sq[0]) + 36'(r_sq[1]) + 36'(r_sq[2])), 26'd0};
                r_res <= '0;
                r_bit <= VW'(1) << 62;
                r_k   <= '0;
            end
            hsn_pkg::B_ROOT: begin
                if (r_v >= trial) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_k   <= r_k + 5'd1;
            end
            hsn_pkg::B_DIVP: begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= {2'd0, r_a[i], 28'd0} + DW'(m >> 1);
                    r_sat[i] <= ({2'd0, r_a[i], 28'd0} + DW'(m >> 1)) >= (DW'(m) << 15);
                    r_q[i]   <= '0;
                end
                r_dm <= DW'(m) << 14;
                r_k  <= '0;
            end
            hsn_pkg::B_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_rem[i] >= r_dm) begin
                        r_rem[i] <= r_rem[i] - r_dm;
                        r_q[i]   <= {r_q[i][13:0], 1'b1};
                    end else begin
                        r_q[i]   <= {r_q[i][13:0], 1'b0};
                    end
                end
                r_dm <= r_dm >> 1;
                r_k  <= r_k + 5'd1;
            end
            default: ;
        endcase
        if (load) begin
            r_nx    <= r_neg[0] ? -$signed({1'b0, qf[0]}) : $signed({1'b0, qf[0]});
            r_ny    <= r_neg[1] ? -$signed({1'b0, qf[1]}) : $signed({1'b0, qf[1]});
            r_nz    <= qf[2];
            r_ocol  <= r_col;
            r_orow  <= r_row;
            r_olast <= r_last;
        end
    end

    assign o_valid = r_ovalid;
    assign o_nx    = r_nx;
    assign o_ny    = r_ny;
    assign o_nz    = r_nz;
    assign o_col   = r_ocol;
    assign o_row   = r_orow;
    assign o_last  = r_olast;

endmodule
